>>> src/trsr_pkg.sv
// Shared constants, codes and types of the triangle scanline rasterizer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package trsr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int REG_BITS       = 12;
    localparam int CFG_IDX_BITS   = 8;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_HEIGHT = 8'd1;

    localparam logic [REG_BITS-1:0] WIDTH_RST  = 12'd640;
    localparam logic [REG_BITS-1:0] HEIGHT_RST = 12'd480;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_NEXT = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_UPPER,
        PH_FINAL
    } t_phase;

    typedef enum logic [2:0] {
        BS_READY,
        BS_SORT,
        BS_SETUP,
        BS_DIV_START,
        BS_DIV_WAIT,
        BS_ADV_A,
        BS_ADV_B
    } t_bstate;

    typedef struct packed {
        logic valid;
        logic load;
    } t_cmd_ctl;

endpackage

`default_nettype wire

>>> src/triangle_scanline_rasterizer_unit.sv
// Top level of the triangle scanline rasterizer: stream ports, buffer size registers,
// input queue and execution engine. Depends on trsr_pkg, trsr_front, trsr_back.
`timescale 1ns / 1ps
`default_nettype none

// A load item (tuser 0) brings three vertices and a colour; the engine sorts them and sets
// up the edges, directly for a flat-top or flat-bottom triangle and through the bit-per-cycle
// split divider for a split one. Each next-pixel item (tuser 1) returns one pixel (a
// nothing-pending reply when idle); at a row change the engine then walks each edge, one
// Bresenham step per cycle, until it steps in y or ends. A two-entry input queue accepts
// until full while the engine works, and the output register holds a pixel until taken.

module triangle_scanline_rasterizer_unit import trsr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // v0x, v0y, v1x, v1y, v2x, v2y, fill_color, zero pad
    input  wire logic [((6*COORD_BITS+24+7)/8)*8-1:0]  s_axis_tdata,
    // operation
    input  wire logic                                  s_axis_tuser,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // pixel_x, pixel_y, pixel_color, zero pad
    output logic [((2*COORD_BITS+24+7)/8)*8-1:0]       m_axis_tdata,
    output logic                                       m_axis_tlast,
    // inside_res, nothing_pending
    output logic [1:0]                                 m_axis_tuser,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]               i_cfg_index,
    input  wire logic [REG_BITS-1:0]                   i_cfg_data
);

    localparam int MW = ((2*COORD_BITS + 24 + 7) / 8) * 8;

    logic [REG_BITS-1:0]           r_width, r_height;
    t_cmd_ctl                      cmd;
    logic [6*COORD_BITS+23:0]      cmd_data;
    logic                          cmd_pop;
    logic signed [COORD_BITS-1:0]  px, py;
    logic [23:0]                   pc;
    logic                          pin, plast, pnp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_IDX_WIDTH) r_width <= i_cfg_data;
            if (i_cfg_index == CFG_IDX_HEIGHT) r_height <= i_cfg_data;
        end
    end

    trsr_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_cmd         (cmd),
        .o_cmd_data    (cmd_data),
        .i_cmd_pop     (cmd_pop)
    );

    trsr_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cmd_data   (cmd_data),
        .o_cmd_pop    (cmd_pop),
        .i_buf_width  (r_width),
        .i_buf_height (r_height),
        .o_m_valid    (m_axis_tvalid),
        .i_m_ready    (m_axis_tready),
        .o_px         (px),
        .o_py         (py),
        .o_pc         (pc),
        .o_inside     (pin),
        .o_last       (plast),
        .o_np         (pnp)
    );

    assign m_axis_tdata = MW'({pc, py, px});
    assign m_axis_tlast = plast;
    assign m_axis_tuser = {pnp, pin};

endmodule

`default_nettype wire

>>> src/trsr_front.sv
// Input side: accepts items, classifies them as load or next-pixel,
// and holds them in a two-entry queue. Depends on trsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trsr_front import trsr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [((6*COORD_BITS+24+7)/8)*8-1:0] s_axis_tdata,
    input  wire logic                            s_axis_tuser,
    output t_cmd_ctl                             o_cmd,
    output logic [6*COORD_BITS+23:0]             o_cmd_data,
    input  wire logic                            i_cmd_pop
);

    localparam int PW = 6*COORD_BITS + 24;

    logic [PW-1:0] r_qd [2];
    logic          r_ql [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          push;

    assign s_axis_tready = (r_cnt != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_qd[r_wp] <= s_axis_tdata[PW-1:0];
            r_ql[r_wp] <= (s_axis_tuser == OP_LOAD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_cmd_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_cmd_pop);
        end
    end

    assign o_cmd.valid = (r_cnt != 2'd0);
    assign o_cmd.load  = r_ql[r_rp];
    assign o_cmd_data  = r_qd[r_rp];

endmodule

`default_nettype wire

>>> src/trsr_div.sv
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
// Divisor is positive. Depends on trsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trsr_div import trsr_pkg::*; #(
    parameter int NW = 2*COORD_BITS_DEF + 2,
    parameter int DW = COORD_BITS_DEF + 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [NW-1:0] i_num,
    input  wire logic [DW-1:0]        i_den,
    output logic                      o_done,
    output logic signed [NW-1:0]      o_quot
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_mag;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [NW-1:0] mag_in, neg_in;
    logic [DW:0]   trial;
    logic          ge;

    assign neg_in = -i_num;
    assign mag_in = i_num[NW-1] ? neg_in : i_num;
    assign trial  = {r_rem[DW-1:0], r_mag[NW-1]};
    assign ge     = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= mag_in;
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_num[NW-1];
        end else if (r_busy) begin
            r_mag <= {r_mag[NW-2:0], ge};
            r_rem <= ge ? (trial - {1'b0, r_den}) : trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_mag) : $signed(r_mag);

endmodule

`default_nettype wire

>>> src/trsr_back.sv
// Execution side: triangle setup (sort, split division) and Bresenham edge walk,
// one span pixel per next-pixel item into an output register. Depends on trsr_pkg, trsr_div.
`timescale 1ns / 1ps
`default_nettype none

module trsr_back import trsr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_cmd_ctl                      i_cmd,
    input  wire logic [6*COORD_BITS+23:0]      i_cmd_data,
    output logic                               o_cmd_pop,
    input  wire logic [REG_BITS-1:0]           i_buf_width,
    input  wire logic [REG_BITS-1:0]           i_buf_height,
    output logic                               o_m_valid,
    input  wire logic                          i_m_ready,
    output logic signed [COORD_BITS-1:0]       o_px,
    output logic signed [COORD_BITS-1:0]       o_py,
    output logic [23:0]                        o_pc,
    output logic                               o_inside,
    output logic                               o_last,
    output logic                               o_np
);

    localparam int C    = COORD_BITS;
    localparam int EW   = C + 2;
    localparam int E2W  = C + 3;
    localparam int NW   = 2*C + 2;
    localparam int DVW  = C + 1;
    localparam int CMPW = ((C > REG_BITS) ? C : REG_BITS) + 1;

    typedef struct packed {
        logic signed [C-1:0]  cx;
        logic signed [C-1:0]  cy;
        logic signed [C-1:0]  ex;
        logic signed [C-1:0]  ey;
        logic [C-1:0]         dx;
        logic [C-1:0]         dy;
        logic                 sx;
        logic                 sy;
        logic signed [EW-1:0] err;
    } t_edge;

    function automatic t_edge f_init(input logic signed [C-1:0] x0, input logic signed [C-1:0] y0,
                                     input logic signed [C-1:0] x1, input logic signed [C-1:0] y1);
        t_edge             e;
        logic signed [C:0] ddx, ddy, nx, ny;
        ddx   = {x1[C-1], x1} - {x0[C-1], x0};
        ddy   = {y1[C-1], y1} - {y0[C-1], y0};
        nx    = -ddx;
        ny    = -ddy;
        e.cx  = x0;
        e.cy  = y0;
        e.ex  = x1;
        e.ey  = y1;
        e.dx  = ddx[C] ? nx[C-1:0] : ddx[C-1:0];
        e.dy  = ddy[C] ? ny[C-1:0] : ddy[C-1:0];
        e.sx  = !(x0 < x1);
        e.sy  = !(y0 < y1);
        e.err = $signed({2'b00, e.dx}) - $signed({2'b00, e.dy});
        return e;
    endfunction

    t_bstate             r_state, n_state;
    t_phase              r_phase, n_phase;
    t_edge               r_edge [2];
    t_edge               n_edge [2];
    logic signed [C-1:0] r_vx [3];
    logic signed [C-1:0] r_vy [3];
    logic signed [C-1:0] n_vx [3];
    logic signed [C-1:0] n_vy [3];
    logic signed [C-1:0] r_lv [6];
    logic signed [C-1:0] n_lv [6];
    logic signed [C-1:0] r_row, n_row, r_spx, n_spx, r_spe, n_spe;
    logic [23:0]         r_color, n_color;
    logic signed [NW-1:0] r_num, n_num;
    logic [DVW-1:0]      r_den, n_den;
    logic                r_ov, n_ov;
    logic signed [C-1:0] r_ox, n_ox, r_oy, n_oy;
    logic [23:0]         r_oc, n_oc;
    logic                r_oi, n_oi, r_ol, n_ol, r_onp, n_onp;

    logic                 div_start, div_done;
    logic signed [NW-1:0] div_quot;

    logic                bh_go;
    logic signed [C-1:0] bh [8];
    logic signed [C-1:0] x3;
    logic signed [C:0]   x3w, dy1, dx2, dy2;
    logic                out_free;
    logic signed [C-1:0] sx_, sy_;
    logic                row_end, last_row, in_buf;
    logic [CMPW-1:0]     cmp_x, cmp_y;

    t_edge                s_sel, s_new;
    logic signed [E2W-1:0] s_e2, s_mdy, s_e2b, s_dxe;
    logic signed [EW-1:0]  s_err1, s_err2;
    logic signed [C-1:0]   s_cx1, s_cy2;
    logic                  s_c1, s_c2, s_f0, s_f1, s_f2, s_done;

    trsr_div #(.NW(NW), .DW(DVW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // one Bresenham step of the selected edge
    always_comb begin
        s_sel  = (r_state == BS_ADV_B) ? r_edge[1] : r_edge[0];
        s_f0   = (s_sel.cx == s_sel.ex) && (s_sel.cy == s_sel.ey);
        s_e2   = {s_sel.err, 1'b0};
        s_mdy  = -$signed({3'b000, s_sel.dy});
        s_c1   = (s_e2 >= s_mdy);
        s_f1   = s_c1 && (s_sel.cx == s_sel.ex);
        s_err1 = s_c1 ? (s_sel.err - $signed({2'b00, s_sel.dy})) : s_sel.err;
        s_cx1  = s_c1 ? (s_sel.sx ? s_sel.cx - C'(1) : s_sel.cx + C'(1)) : s_sel.cx;
        s_e2b  = {s_err1, 1'b0};
        s_dxe  = $signed({3'b000, s_sel.dx});
        s_c2   = (s_e2b <= s_dxe);
        s_f2   = s_c2 && (s_sel.cy == s_sel.ey);
        s_err2 = s_c2 ? (s_err1 + $signed({2'b00, s_sel.dx})) : s_err1;
        s_cy2  = s_c2 ? (s_sel.sy ? s_sel.cy - C'(1) : s_sel.cy + C'(1)) : s_sel.cy;
        s_new  = s_sel;
        if (!s_f0 && !s_f1) begin
            s_new.cx  = s_cx1;
            s_new.err = s_err1;
            if (!s_f2) begin
                s_new.cy  = s_cy2;
                s_new.err = s_err2;
            end
        end
        s_done = s_f0 || s_f1 || s_f2 || s_c2;
    end

    assign out_free = !r_ov || i_m_ready;
    assign sx_      = r_spx;
    assign sy_      = r_row;
    assign row_end  = (sx_ >= r_spe);
    assign last_row = (sy_ >= r_edge[0].ey);
    assign cmp_x    = CMPW'(unsigned'(sx_));
    assign cmp_y    = CMPW'(unsigned'(sy_));
    assign in_buf   = !sx_[C-1] && (cmp_x < CMPW'(i_buf_width)) &&
                      !sy_[C-1] && (cmp_y < CMPW'(i_buf_height));
    assign dy1      = {r_vy[1][C-1], r_vy[1]} - {r_vy[0][C-1], r_vy[0]};
    assign dx2      = {r_vx[2][C-1], r_vx[2]} - {r_vx[0][C-1], r_vx[0]};
    assign dy2      = {r_vy[2][C-1], r_vy[2]} - {r_vy[0][C-1], r_vy[0]};
    assign x3w      = {r_vx[0][C-1], r_vx[0]} + div_quot[C:0];
    assign x3       = x3w[C-1:0];

    always_comb begin
        logic signed [C-1:0] tx, ty;
        tx        = '0;
        ty        = '0;
        n_state   = r_state;
        n_phase   = r_phase;
        n_edge    = r_edge;
        n_vx      = r_vx;
        n_vy      = r_vy;
        n_lv      = r_lv;
        n_row     = r_row;
        n_spx     = r_spx;
        n_spe     = r_spe;
        n_color   = r_color;
        n_num     = r_num;
        n_den     = r_den;
        n_ov      = r_ov && !i_m_ready;
        n_ox      = r_ox;
        n_oy      = r_oy;
        n_oc      = r_oc;
        n_oi      = r_oi;
        n_ol      = r_ol;
        n_onp     = r_onp;
        o_cmd_pop = 1'b0;
        div_start = 1'b0;
        bh_go     = 1'b0;
        for (int i = 0; i < 8; i++) bh[i] = '0;

        unique case (r_state)
            BS_READY: begin
                if (i_cmd.valid && i_cmd.load) begin
                    o_cmd_pop = 1'b1;
                    for (int i = 0; i < 3; i++) begin
                        n_vx[i] = i_cmd_data[2*i*C +: C];
                        n_vy[i] = i_cmd_data[(2*i+1)*C +: C];
                    end
                    n_color = i_cmd_data[6*C +: 24];
                    n_state = BS_SORT;
                end else if (i_cmd.valid && out_free) begin
                    o_cmd_pop = 1'b1;
                    n_ov      = 1'b1;
                    if (r_phase == PH_IDLE) begin
                        n_ox  = '0;
                        n_oy  = '0;
                        n_oc  = '0;
                        n_oi  = 1'b0;
                        n_ol  = 1'b0;
                        n_onp = 1'b1;
                    end else begin
                        n_ox  = sx_;
                        n_oy  = sy_;
                        n_oc  = r_color;
                        n_oi  = in_buf;
                        n_ol  = (r_phase == PH_FINAL) && row_end && last_row;
                        n_onp = 1'b0;
                        priority if (!row_end) begin
                            n_spx = sx_ + C'(1);
                        end else if (last_row) begin
                            if (r_phase == PH_UPPER) begin
                                bh_go = 1'b1;
                                bh[0] = r_lv[0]; bh[1] = r_lv[1];
                                bh[2] = r_lv[2]; bh[3] = r_lv[3];
                                bh[4] = r_lv[4]; bh[5] = r_lv[5];
                                bh[6] = r_lv[2]; bh[7] = r_lv[3];
                                n_phase = PH_FINAL;
                            end else begin
                                n_phase = PH_IDLE;
                            end
                        end else begin
                            n_state = BS_ADV_A;
                        end
                    end
                end
            end
            BS_SORT: begin
                if (n_vy[0] > n_vy[1]) begin
                    tx = n_vx[0]; ty = n_vy[0];
                    n_vx[0] = n_vx[1]; n_vy[0] = n_vy[1];
                    n_vx[1] = tx; n_vy[1] = ty;
                end
                if (n_vy[0] > n_vy[2]) begin
                    tx = n_vx[0]; ty = n_vy[0];
                    n_vx[0] = n_vx[2]; n_vy[0] = n_vy[2];
                    n_vx[2] = tx; n_vy[2] = ty;
                end
                if (n_vy[1] > n_vy[2]) begin
                    tx = n_vx[1]; ty = n_vy[1];
                    n_vx[1] = n_vx[2]; n_vy[1] = n_vy[2];
                    n_vx[2] = tx; n_vy[2] = ty;
                end
                n_state = BS_SETUP;
            end
            BS_SETUP: begin
                priority if (r_vy[0] == r_vy[1]) begin
                    bh_go = 1'b1;
                    bh[0] = r_vx[0]; bh[1] = r_vy[0]; bh[2] = r_vx[2]; bh[3] = r_vy[2];
                    bh[4] = r_vx[1]; bh[5] = r_vy[1]; bh[6] = r_vx[2]; bh[7] = r_vy[2];
                    n_phase = PH_FINAL;
                    n_state = BS_READY;
                end else if (r_vy[1] == r_vy[2]) begin
                    bh_go = 1'b1;
                    bh[0] = r_vx[0]; bh[1] = r_vy[0]; bh[2] = r_vx[1]; bh[3] = r_vy[1];
                    bh[4] = r_vx[0]; bh[5] = r_vy[0]; bh[6] = r_vx[2]; bh[7] = r_vy[2];
                    n_phase = PH_FINAL;
                    n_state = BS_READY;
                end else begin
                    n_num   = NW'(dy1 * dx2);
                    n_den   = dy2;
                    n_state = BS_DIV_START;
                end
            end
            BS_DIV_START: begin
                div_start = 1'b1;
                n_state   = BS_DIV_WAIT;
            end
            BS_DIV_WAIT: begin
                if (div_done) begin
                    n_lv[0] = x3;      n_lv[1] = r_vy[1];
                    n_lv[2] = r_vx[2]; n_lv[3] = r_vy[2];
                    n_lv[4] = r_vx[1]; n_lv[5] = r_vy[1];
                    bh_go = 1'b1;
                    bh[0] = r_vx[0]; bh[1] = r_vy[0]; bh[2] = r_vx[1]; bh[3] = r_vy[1];
                    bh[4] = r_vx[0]; bh[5] = r_vy[0]; bh[6] = x3;      bh[7] = r_vy[1];
                    n_phase = PH_UPPER;
                    n_state = BS_READY;
                end
            end
            BS_ADV_A: begin
                n_edge[0] = s_new;
                if (s_done) n_state = BS_ADV_B;
            end
            BS_ADV_B: begin
                n_edge[1] = s_new;
                if (s_done) begin
                    n_row   = sy_ + C'(1);
                    n_spx   = (r_edge[0].cx < s_new.cx) ? r_edge[0].cx : s_new.cx;
                    n_spe   = (r_edge[0].cx < s_new.cx) ? s_new.cx : r_edge[0].cx;
                    n_state = BS_READY;
                end
            end
            default: n_state = BS_READY;
        endcase

        if (bh_go) begin
            n_edge[0] = f_init(bh[0], bh[1], bh[2], bh[3]);
            n_edge[1] = f_init(bh[4], bh[5], bh[6], bh[7]);
            n_row     = bh[1];
            n_spx     = (bh[0] < bh[4]) ? bh[0] : bh[4];
            n_spe     = (bh[0] < bh[4]) ? bh[4] : bh[0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_edge  <= n_edge;
        r_vx    <= n_vx;
        r_vy    <= n_vy;
        r_lv    <= n_lv;
        r_row   <= n_row;
        r_spx   <= n_spx;
        r_spe   <= n_spe;
        r_color <= n_color;
        r_num   <= n_num;
        r_den   <= n_den;
        r_ox    <= n_ox;
        r_oy    <= n_oy;
        r_oc    <= n_oc;
        r_oi    <= n_oi;
        r_ol    <= n_ol;
        r_onp   <= n_onp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_READY;
            r_phase <= PH_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_ov    <= n_ov;
        end
    end

    assign o_m_valid = r_ov;
    assign o_px      = r_ox;
    assign o_py      = r_oy;
    assign o_pc      = r_oc;
    assign o_inside  = r_oi;
    assign o_last    = r_ol;
    assign o_np      = r_onp;

endmodule

`default_nettype wire

>>> src/trsr_checker.sv
// Port-level checks of the rasterizer output stream, bound to the top level.
// Depends on trsr_pkg and triangle_scanline_rasterizer_unit.
`timescale 1ns / 1ps
`default_nettype none

module trsr_checker import trsr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 m_axis_tvalid,
    input wire logic                                 m_axis_tready,
    input wire logic [((2*COORD_BITS+24+7)/8)*8-1:0] m_axis_tdata,
    input wire logic                                 m_axis_tlast,
    input wire logic [1:0]                           m_axis_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item dropped or changed while stalled");

    a_np_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tlast && m_axis_tuser[1]))
        else $error("idle reply flagged as last pixel");

    a_np_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0 && !m_axis_tuser[0])
        else $error("idle reply carries pixel data");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind triangle_scanline_rasterizer_unit trsr_checker #(.COORD_BITS(COORD_BITS)) u_chk (.*);

`default_nettype wire
